// ===== sv/npp_pkg.sv =====
// Package for the next-permutation block: command and status structs, state codes
// and fixed field widths shared by the controller, the datapath and the top level.
// It depends on nothing else.
package npp_pkg;

  localparam int CFG_W      = 5;
  localparam int ELEM_W     = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;
  localparam logic [CFG_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV_RD,
    S_PIV_CHK,
    S_SUC_RD,
    S_SUC_CHK,
    S_SW1,
    S_SW2,
    S_REV_CHK,
    S_REV_LO,
    S_REV_HI,
    S_REV_W1,
    S_REV_W2,
    S_EM_RD,
    S_EM_PUSH
  } state_t;

  typedef enum logic [1:0] {
    WS_SV,
    WS_PV,
    WS_RD,
    WS_TV
  } wsrc_t;

  typedef enum logic [2:0] {
    P_HOLD,
    P_TOP,
    P_ZERO,
    P_DEC,
    P_INC
  } pop_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_PIV,
    I_INC
  } iop_t;

  typedef struct packed {
    logic  rd_lo;
    logic  we;
    logic  wr_lo;
    wsrc_t wsrc;
    pop_t  p_op;
    iop_t  i_op;
    logic  prev_ld;
    logic  sv_ld;
    logic  tv_ld;
    logic  par_flip;
    logic  clear;
    logic  adv_set;
    logic  adv_clr;
    logic  out_ld;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic p_top;
    logic p_zero;
    logic lo_lt_hi;
    logic short_len;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/npp_dp.sv =====
// Datapath of the next-permutation block: permutation memory with valid bits,
// index counters, compare logic, parity, length register and output register.
// It depends on npp_pkg.
module npp_dp #(
  parameter int MAX_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [npp_pkg::CFG_W-1:0]    cfg_wdata,
  input  npp_pkg::cmd_t                cmd,
  output npp_pkg::sts_t                st,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [npp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import npp_pkg::*;

  localparam int IW    = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > MAX_LEN) begin
      r = LEN_W'(MAX_LEN);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  logic [CFG_W-1:0]  length;
  logic [IW-1:0]     mem [MAX_LEN];
  logic [MAX_LEN-1:0] vld;
  logic [IW-1:0]     rd_raw;
  logic              rd_vld;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     p;
  logic [IW-1:0]     i;
  logic [IW-1:0]     prev;
  logic [IW-1:0]     pv;
  logic [IW-1:0]     sv;
  logic [IW-1:0]     tv;
  logic              parity;
  logic              adv;
  logic              out_valid;
  logic [ELEM_W-1:0] out_elem;
  logic              out_last;
  logic              out_adv;
  logic              out_odd;

  logic [LEN_W-1:0]  n;
  logic [IW-1:0]     top_idx;
  logic [IW-1:0]     rdata;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic [IW-1:0]     wdata;
  logic              len_change;
  logic              clear_all;

  assign n          = eff_len(length);
  assign top_idx    = IW'(n - LEN_W'(1));
  assign rdata      = rd_vld ? rd_raw : rd_addr;
  assign raddr      = cmd.rd_lo ? i : p;
  assign waddr      = cmd.wr_lo ? i : p;
  assign len_change = cfg_we && (eff_len(cfg_wdata) != n);
  assign clear_all  = cmd.clear || len_change;

  always_comb begin
    case (cmd.wsrc)
      WS_SV:   wdata = sv;
      WS_PV:   wdata = pv;
      WS_RD:   wdata = rdata;
      WS_TV:   wdata = tv;
      default: wdata = sv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    rd_raw  <= mem[raddr];
    rd_vld  <= vld[raddr];
    rd_addr <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld <= '0;
    end else if (cmd.we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_RESET;
    end else if (cfg_we) begin
      length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      parity <= 1'b0;
    end else if (cmd.par_flip) begin
      parity <= ~parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adv <= 1'b0;
    end else if (cmd.adv_set) begin
      adv <= 1'b1;
    end else if (cmd.adv_clr) begin
      adv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.p_op)
      P_HOLD:  p <= p;
      P_TOP:   p <= top_idx;
      P_ZERO:  p <= '0;
      P_DEC:   p <= p - IW'(1);
      P_INC:   p <= p + IW'(1);
      default: p <= p;
    endcase
    case (cmd.i_op)
      I_HOLD:  i <= i;
      I_PIV: begin
        i  <= p;
        pv <= rdata;
      end
      I_INC:   i <= i + IW'(1);
      default: i <= i;
    endcase
    if (cmd.prev_ld) begin
      prev <= rdata;
    end
    if (cmd.sv_ld) begin
      sv <= rdata;
    end
    if (cmd.tv_ld) begin
      tv <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_elem <= ELEM_W'(rdata);
      out_last <= (p == top_idx);
      out_adv  <= adv;
      out_odd  <= parity;
    end
  end

  assign st.lt        = rdata < prev;
  assign st.gt        = rdata > pv;
  assign st.p_top     = (p == top_idx);
  assign st.p_zero    = (p == '0);
  assign st.lo_lt_hi  = (i < p);
  assign st.short_len = (n < LEN_W'(2));
  assign st.out_free  = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_odd, out_adv, out_elem};

endmodule

// ===== sv/npp_ctrl.sv =====
// Controller of the next-permutation block: the sequencer that runs pivot search,
// successor search, swap, suffix reversal and emission through datapath commands.
// It depends on npp_pkg.
module npp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic          restart,
  input  npp_pkg::sts_t st,
  output npp_pkg::cmd_t cmd
);
  import npp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (restart || st.short_len) begin
            state_next = S_EM_RD;
          end else begin
            state_next = S_PIV_RD;
          end
        end
      end
      S_PIV_RD:  state_next = S_PIV_CHK;
      S_PIV_CHK: begin
        if (st.p_top) begin
          state_next = S_PIV_RD;
        end else if (st.lt) begin
          state_next = S_SUC_RD;
        end else if (st.p_zero) begin
          state_next = S_EM_RD;
        end else begin
          state_next = S_PIV_RD;
        end
      end
      S_SUC_RD:  state_next = S_SUC_CHK;
      S_SUC_CHK: state_next = st.gt ? S_SW1 : S_SUC_RD;
      S_SW1:     state_next = S_SW2;
      S_SW2:     state_next = S_REV_CHK;
      S_REV_CHK: state_next = st.lo_lt_hi ? S_REV_LO : S_EM_RD;
      S_REV_LO:  state_next = S_REV_HI;
      S_REV_HI:  state_next = S_REV_W1;
      S_REV_W1:  state_next = S_REV_W2;
      S_REV_W2:  state_next = S_REV_CHK;
      S_EM_RD:   state_next = S_EM_PUSH;
      S_EM_PUSH: begin
        if (st.out_free) begin
          state_next = st.p_top ? S_IDLE : S_EM_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (restart) begin
            cmd.clear   = 1'b1;
            cmd.adv_set = 1'b1;
            cmd.p_op    = P_ZERO;
          end else if (st.short_len) begin
            cmd.adv_clr = 1'b1;
            cmd.p_op    = P_ZERO;
          end else begin
            cmd.p_op = P_TOP;
          end
        end
      end
      S_PIV_CHK: begin
        if (st.p_top) begin
          cmd.prev_ld = 1'b1;
          cmd.p_op    = P_DEC;
        end else if (st.lt) begin
          cmd.i_op    = I_PIV;
          cmd.adv_set = 1'b1;
          cmd.p_op    = P_TOP;
        end else if (st.p_zero) begin
          cmd.adv_clr = 1'b1;
          cmd.p_op    = P_ZERO;
        end else begin
          cmd.prev_ld = 1'b1;
          cmd.p_op    = P_DEC;
        end
      end
      S_SUC_CHK: begin
        if (st.gt) begin
          cmd.sv_ld = 1'b1;
        end else begin
          cmd.p_op = P_DEC;
        end
      end
      S_SW1: begin
        cmd.we    = 1'b1;
        cmd.wr_lo = 1'b1;
        cmd.wsrc  = WS_SV;
      end
      S_SW2: begin
        cmd.we       = 1'b1;
        cmd.wsrc     = WS_PV;
        cmd.par_flip = 1'b1;
        cmd.i_op     = I_INC;
        cmd.p_op     = P_TOP;
      end
      S_REV_CHK: begin
        if (!st.lo_lt_hi) begin
          cmd.p_op = P_ZERO;
        end
      end
      S_REV_LO: begin
        cmd.rd_lo = 1'b1;
      end
      S_REV_HI: begin
        cmd.tv_ld = 1'b1;
      end
      S_REV_W1: begin
        cmd.we    = 1'b1;
        cmd.wr_lo = 1'b1;
        cmd.wsrc  = WS_RD;
      end
      S_REV_W2: begin
        cmd.we       = 1'b1;
        cmd.wsrc     = WS_TV;
        cmd.par_flip = 1'b1;
        cmd.i_op     = I_INC;
        cmd.p_op     = P_DEC;
      end
      S_EM_PUSH: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          if (!st.p_top) begin
            cmd.p_op = P_INC;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/next_permutation_parity.sv =====
// Next lexicographic permutation with parity, one element per output word.
// An advance runs pivot search, successor search, swap and suffix reversal, then emits the result;
// the pivot and successor scans read one entry at a time, all through one memory read port.
// A restart clears to the identity permutation; emission reads then pushes each element, waiting while stalled.
// Synchronous reset loads the identity permutation, even parity and length 16.
module next_permutation_parity #(
  parameter int MAX_LEN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [npp_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [npp_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [npp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [3:0] element, [4] advanced, [5] odd
  output logic                            m_axis_tlast
);
  import npp_pkg::*;

  cmd_t cmd;
  sts_t st;

  npp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .restart       (s_axis_tdata[0]),
    .st            (st),
    .cmd           (cmd)
  );

  npp_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .st            (st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous word still in progress");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> st.out_free)
    else $error("output register overwritten before it was taken");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> !s_axis_tready)
    else $error("permutation memory written while idle");

endmodule
